### rtl/core/lfu_pkg.sv
package lfu_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int OCC_W   = $clog2(DEPTH + 1);
  localparam int AGE_W   = IDX_W;
  localparam int COUNT_W = 16;
  localparam int KEY_W   = 16;
  localparam int VAL_W   = 31;
  localparam int CAP_W   = 5;
  localparam int CAP_RESET = 16;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } rsp_t;

  // Update broadcast to every cell
  typedef struct packed {
    logic             en;
    logic             insert;     // 1: new entry at target, 0: touch target
    logic             wr_value;   // touch also stores value
    logic [IDX_W-1:0] target;
    logic             use_thresh; // only ages below thresh move up
    logic [AGE_W-1:0] thresh;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } cell_cmd_t;

  // Per-cell status seen by the controller
  typedef struct packed {
    logic             match;
    logic [AGE_W-1:0] age;
    logic [VAL_W-1:0] value;
  } cell_stat_t;

  // Victim candidate handed down the chain
  typedef struct packed {
    logic               found;
    logic [IDX_W-1:0]   idx;
    logic [COUNT_W-1:0] count;
    logic [AGE_W-1:0]   age;
    logic [KEY_W-1:0]   key;
  } cand_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SEARCH
  } ctrl_state_t;

  function automatic logic [OCC_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
    logic [OCC_W-1:0] r;
    if (c == '0) begin
      r = OCC_W'(1);
    end else if (int'(c) > DEPTH) begin
      r = OCC_W'(DEPTH);
    end else begin
      r = OCC_W'(c);
    end
    return r;
  endfunction

endpackage

### rtl/core/lfu_cell.sv
module lfu_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [lfu_pkg::IDX_W-1:0] cell_idx,
  input  logic [lfu_pkg::KEY_W-1:0] lookup_key,
  input  lfu_pkg::cell_cmd_t      cmd,
  input  lfu_pkg::cand_t          cand_in,
  output lfu_pkg::cand_t          cand_out,
  output lfu_pkg::cell_stat_t     stat
);
  import lfu_pkg::*;

  logic               valid;
  logic [KEY_W-1:0]   key;
  logic [VAL_W-1:0]   value;
  logic [COUNT_W-1:0] count;
  logic [AGE_W-1:0]   age;
  logic               better;

  // Lookup compare
  assign stat.match = valid && (key == lookup_key);
  assign stat.age   = age;
  assign stat.value = value;

  // Entry update
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.en && cmd.target == cell_idx && cmd.insert) begin
      valid <= 1'b1;
    end
    if (cmd.en) begin
      if (cmd.target == cell_idx) begin
        age <= '0;
        if (cmd.insert) begin
          key   <= cmd.key;
          value <= cmd.value;
          count <= COUNT_W'(1);
        end else begin
          if (count != '1) count <= count + COUNT_W'(1);
          if (cmd.wr_value) value <= cmd.value;
        end
      end else if (valid && (!cmd.use_thresh || age < cmd.thresh)) begin
        age <= age + AGE_W'(1);
      end
    end
  end

  // Victim candidate: fewest uses, then oldest
  assign better = valid && (!cand_in.found || count < cand_in.count ||
                  (count == cand_in.count && age > cand_in.age));

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_out.found <= 1'b0;
    end else begin
      cand_out.found <= cand_in.found | better;
    end
    if (better) begin
      cand_out.idx   <= cell_idx;
      cand_out.count <= count;
      cand_out.age   <= age;
      cand_out.key   <= key;
    end else begin
      cand_out.idx   <= cand_in.idx;
      cand_out.count <= cand_in.count;
      cand_out.age   <= cand_in.age;
      cand_out.key   <= cand_in.key;
    end
  end

endmodule

### rtl/core/lfu_cache_lookup_replace.sv
// LFU key-value cache with LRU tie break, built as a row of DEPTH entry
// cells. A get, a hit, or a put that finds room takes two steps: one in
// which the item is taken into the item register, then one that compares all
// keys in parallel and updates the cells, at whose end the result is
// registered. A put of a new key into a full cache also runs the victim
// search, a candidate record passed one cell per cycle down the row, before
// the result is registered. A finished result that cannot leave because the
// output is stalled keeps the block in its last step. One item is in
// flight at a time; a finished result waits in the output register while the
// next item is taken. Capacity is written over the APB port at byte address 0.
module lfu_cache_lookup_replace (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  lfu_pkg::req_t             req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output lfu_pkg::rsp_t             rsp,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import lfu_pkg::*;

  ctrl_state_t      state, state_next;
  req_t             item;
  logic [CAP_W-1:0] capacity;
  logic [OCC_W-1:0] occ;
  logic [IDX_W-1:0] cnt;
  cell_cmd_t        cmd;
  cell_stat_t       stat [DEPTH];
  cand_t            chain [DEPTH+1];
  logic [DEPTH-1:0] match_vec;
  logic             hit;
  logic [AGE_W-1:0] hit_age;
  logic [VAL_W-1:0] hit_value;
  logic [IDX_W-1:0] hit_idx;
  logic             full;
  logic             out_free;
  logic             done;
  rsp_t             result;

  // Config port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(CAP_RESET);
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end
  assign prdata = (paddr[2] == 1'b0) ? {{(32-CAP_W){1'b0}}, capacity} : '0;

  // Cell row
  assign chain[0] = '0;
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    lfu_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_idx   (IDX_W'(i)),
      .lookup_key (item.key),
      .cmd        (cmd),
      .cand_in    (chain[i]),
      .cand_out   (chain[i+1]),
      .stat       (stat[i])
    );
    assign match_vec[i] = stat[i].match;
  end

  // Gather the (unique) hit
  always_comb begin
    hit_age   = '0;
    hit_value = '0;
    hit_idx   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (stat[i].match) begin
        hit_age   = hit_age | stat[i].age;
        hit_value = hit_value | stat[i].value;
        hit_idx   = hit_idx | IDX_W'(i);
      end
    end
  end
  assign hit      = |match_vec;
  assign full     = occ >= eff_cap(capacity);
  assign out_free = !rsp_valid || !rsp_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_LOOK;
      end
      ST_LOOK: begin
        if (!hit && item.action == ACT_PUT && full) begin
          state_next = ST_SEARCH;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_SEARCH: begin
        if (cnt == IDX_W'(DEPTH - 1) && out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs: cell command and result
  always_comb begin
    cmd        = '0;
    cmd.key    = item.key;
    cmd.value  = item.write_value;
    result     = '0;
    done       = 1'b0;
    case (state)
      ST_LOOK: begin
        if (hit) begin
          done           = out_free;
          cmd.en         = out_free;
          cmd.target     = hit_idx;
          cmd.use_thresh = 1'b1;
          cmd.thresh     = hit_age;
          cmd.wr_value   = (item.action == ACT_PUT);
          result.hit     = 1'b1;
          result.read_value = (item.action == ACT_GET) ? hit_value : '0;
        end else if (item.action == ACT_GET) begin
          done = out_free;
        end else if (!full) begin
          done       = out_free;
          cmd.en     = out_free;
          cmd.insert = 1'b1;
          cmd.target = occ[IDX_W-1:0];
        end
      end
      ST_SEARCH: begin
        if (cnt == IDX_W'(DEPTH - 1) && out_free) begin
          done           = 1'b1;
          cmd.en         = 1'b1;
          cmd.insert     = 1'b1;
          cmd.target     = chain[DEPTH].idx;
          cmd.use_thresh = 1'b1;
          cmd.thresh     = chain[DEPTH].age;
          result.evicted     = 1'b1;
          result.evicted_key = chain[DEPTH].key;
        end
      end
      default: ;
    endcase
  end

  assign req_stall = (state != ST_IDLE);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      occ       <= '0;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_SEARCH) begin
        if (cnt != IDX_W'(DEPTH - 1)) cnt <= cnt + IDX_W'(1);
      end else begin
        cnt <= '0;
      end
      if (cmd.en && cmd.insert && !cmd.use_thresh) occ <= occ + OCC_W'(1);
      if (done) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Item and result registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) item <= req;
    if (done) rsp <= result;
  end

  // Keys are unique among valid entries
  assert property (@(posedge clk) disable iff (rst) $onehot0(match_vec))
    else $error("more than one entry matches the key");

  assert property (@(posedge clk) disable iff (rst) int'(occ) <= DEPTH)
    else $error("occupancy above depth");

  assert property (@(posedge clk) disable iff (rst)
    state == ST_SEARCH |-> item.action == ACT_PUT && !hit)
    else $error("victim search without a put miss");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH && done) |-> chain[DEPTH].found)
    else $error("eviction without a victim");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.evicted |-> !rsp.hit)
    else $error("eviction reported on a hit");

endmodule
